@@ src/dpd_pkg.sv @@
// Shared widths, register indexes and pipeline constants for the depth pixel deprojection block
`default_nettype none

package dpd_pkg;

    // Field widths
    localparam int COL_W      = 12;
    localparam int ROW_W      = 12;
    localparam int DEPTH_W    = 16;
    localparam int COEFF_W    = 32;
    localparam int SCALE_W    = 24;
    localparam int X_W        = 40;
    localparam int Z_W        = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Internal arithmetic widths
    localparam int PROD_W  = COEFF_W + COL_W + 1;   // coefficient times pixel position
    localparam int RAY_W   = PROD_W + 2;            // sum of two products and an offset
    localparam int MAG_W   = PROD_W;                // ray magnitude
    localparam int LO_W    = 32;                    // low slice of the ray magnitude
    localparam int HI_W    = MAG_W - LO_W;          // high slice of the ray magnitude
    localparam int PLO_W   = LO_W + Z_W;
    localparam int PHI_W   = HI_W + Z_W;
    localparam int FRAC_W  = 28;                    // Q4.28 fraction bits
    localparam int HI_SH   = LO_W - FRAC_W;
    localparam int Q_W     = PHI_W + HI_SH + 1;
    localparam int ZPROD_W = DEPTH_W + SCALE_W;
    localparam int Z_SH    = 8;                     // Q.16 product down to Q.8

    // Saturation limits on the magnitude of X and Y
    localparam logic [Q_W-1:0] Q_POS_LIMIT = Q_W'(64'h7F_FFFF_FFFF);
    localparam logic [Q_W-1:0] Q_NEG_LIMIT = Q_W'(64'h80_0000_0000);

    // Number of register stages from input to output
    localparam int PIPE_STAGES = 6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RAY_X_COL   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RAY_X_ROW   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RAY_X_OFS   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_RAY_Y_COL   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_RAY_Y_ROW   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_RAY_Y_OFS   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_MM_PER_UNIT = CFG_IDX_W'(6);

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

endpackage

`default_nettype wire

@@ src/dpd_ifs.sv @@
// Valid/ready channel interfaces for pixels, points and register writes
`default_nettype none

interface dpd_pixel_if;
    logic                           valid;
    logic                           ready;
    logic [dpd_pkg::COL_W-1:0]      pixel_col;
    logic [dpd_pkg::ROW_W-1:0]      pixel_row;
    logic [dpd_pkg::DEPTH_W-1:0]    depth_raw;

    modport source (output valid, pixel_col, pixel_row, depth_raw, input ready);
    modport sink   (input valid, pixel_col, pixel_row, depth_raw, output ready);
endinterface

interface dpd_point_if;
    logic                           valid;
    logic                           ready;
    logic signed [dpd_pkg::X_W-1:0] point_x;
    logic signed [dpd_pkg::X_W-1:0] point_y;
    logic [dpd_pkg::Z_W-1:0]        point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface dpd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dpd_pkg::CFG_IDX_W-1:0]   index;
    logic [dpd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/depth_pixel_deprojection.sv @@
// Depth pixel deprojection top level: six-stage pipeline from depth pixel to 3D point.
// Each pixel passes through the stage registers in order; the point is driven from the stage 6 output register.
// Throughput: one pixel per cycle unless the output stalls; the two 32x32 ray-by-depth multiplies set stage depth.
// A stall on the point output backs up through the stage valid bits; nothing is dropped.
// Reset clears all stage valid bits and loads the configuration registers with their reset values.
`default_nettype none

module depth_pixel_deprojection #(
    parameter int MAX_IMAGE_DIM = 4096
) (
    input  wire           clk,
    input  wire           rst_n,
    dpd_pixel_if.sink     pixel,
    dpd_point_if.source   point,
    dpd_cfg_if.sink       cfg
);

    import dpd_pkg::*;

    localparam logic [16:0] POS_LIMIT = 17'(MAX_IMAGE_DIM - 1);

    // Configuration registers
    logic signed [COEFF_W-1:0] ray_x_col_reg, ray_x_row_reg, ray_x_ofs_reg;
    logic signed [COEFF_W-1:0] ray_y_col_reg, ray_y_row_reg, ray_y_ofs_reg;
    logic [SCALE_W-1:0]        mm_per_unit_reg;

    // Pipeline control
    logic [PIPE_STAGES-1:0] vld_reg, vld_next, ld, src_vld, en;

    // Stage 1: products
    logic [COL_W-1:0]          col_clamped;
    logic [ROW_W-1:0]          row_clamped;
    logic signed [PROD_W-1:0]  pxc_next, pxr_next, pyc_next, pyr_next;
    logic signed [PROD_W-1:0]  pxc_reg, pxr_reg, pyc_reg, pyr_reg;
    logic [ZPROD_W-1:0]        zprod_next, zprod_reg;

    // Stage 2: rays and depth
    logic signed [RAY_W-1:0]   ray_x_next, ray_y_next, ray_x_reg, ray_y_reg;
    logic [Z_W-1:0]            z2_reg;

    // Stage 3: sign and magnitude
    logic [RAY_W-1:0]          mag_x_full, mag_y_full;
    logic [MAG_W-1:0]          mag_x_reg, mag_y_reg;
    logic                      neg_x3_reg, neg_y3_reg;
    logic [Z_W-1:0]            z3_reg;

    // Stage 4: partial products
    logic [PLO_W-1:0]          plo_x_next, plo_y_next, plo_x_reg, plo_y_reg;
    logic [PHI_W-1:0]          phi_x_next, phi_y_next, phi_x_reg, phi_y_reg;
    logic                      neg_x4_reg, neg_y4_reg;
    logic [Z_W-1:0]            z4_reg;

    // Stage 5: truncated quotient magnitude
    logic [Q_W-1:0]            q_x_next, q_y_next, q_x_reg, q_y_reg;
    logic                      neg_x5_reg, neg_y5_reg;
    logic [Z_W-1:0]            z5_reg;

    // Stage 6: output register
    logic [X_W-1:0]            pt_x_next, pt_y_next, pt_x_reg, pt_y_reg;
    logic [Z_W-1:0]            pt_z_reg;

    // Saturate a magnitude and apply its sign
    function automatic logic [X_W-1:0] saturate(input logic [Q_W-1:0] q, input logic neg);
        logic [Q_W-1:0] lim;
        if (neg)
        begin
            lim = (q > Q_NEG_LIMIT) ? Q_NEG_LIMIT : q;
            lim = ~lim + Q_W'(1);
        end
        else
        begin
            lim = (q > Q_POS_LIMIT) ? Q_POS_LIMIT : q;
        end
        return lim[X_W-1:0];
    endfunction

    // Register writes; indexes past the list are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_x_col_reg   <= '0;
            ray_x_row_reg   <= '0;
            ray_x_ofs_reg   <= '0;
            ray_y_col_reg   <= '0;
            ray_y_row_reg   <= '0;
            ray_y_ofs_reg   <= '0;
            mm_per_unit_reg <= SCALE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_RAY_X_COL:   ray_x_col_reg   <= cfg.data;
                REG_RAY_X_ROW:   ray_x_row_reg   <= cfg.data;
                REG_RAY_X_OFS:   ray_x_ofs_reg   <= cfg.data;
                REG_RAY_Y_COL:   ray_y_col_reg   <= cfg.data;
                REG_RAY_Y_ROW:   ray_y_row_reg   <= cfg.data;
                REG_RAY_Y_OFS:   ray_y_ofs_reg   <= cfg.data;
                REG_MM_PER_UNIT: mm_per_unit_reg <= cfg.data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Ready chain: a stage loads when it is empty or its contents move on
    always_comb
    begin
        ld[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || point.ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
        begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end

    assign src_vld  = {vld_reg[PIPE_STAGES-2:0], pixel.valid};
    assign en       = ld & src_vld;
    assign vld_next = (ld & src_vld) | (~ld & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign pixel.ready = ld[0];

    // Stage 1: clamp position, form coefficient and depth products
    always_comb
    begin
        col_clamped = ({5'b0, pixel.pixel_col} > POS_LIMIT) ? POS_LIMIT[COL_W-1:0]
                                                             : pixel.pixel_col;
        row_clamped = ({5'b0, pixel.pixel_row} > POS_LIMIT) ? POS_LIMIT[ROW_W-1:0]
                                                             : pixel.pixel_row;
    end

    assign pxc_next   = ray_x_col_reg * $signed({1'b0, col_clamped});
    assign pxr_next   = ray_x_row_reg * $signed({1'b0, row_clamped});
    assign pyc_next   = ray_y_col_reg * $signed({1'b0, col_clamped});
    assign pyr_next   = ray_y_row_reg * $signed({1'b0, row_clamped});
    assign zprod_next = ZPROD_W'(pixel.depth_raw) * ZPROD_W'(mm_per_unit_reg);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pxc_reg   <= pxc_next;
            pxr_reg   <= pxr_next;
            pyc_reg   <= pyc_next;
            pyr_reg   <= pyr_next;
            zprod_reg <= zprod_next;
        end
    end

    // Stage 2: sum the ray terms, truncate depth to Q.8
    assign ray_x_next = RAY_W'(pxc_reg) + RAY_W'(pxr_reg) + RAY_W'(ray_x_ofs_reg);
    assign ray_y_next = RAY_W'(pyc_reg) + RAY_W'(pyr_reg) + RAY_W'(ray_y_ofs_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ray_x_reg <= ray_x_next;
            ray_y_reg <= ray_y_next;
            z2_reg    <= zprod_reg[Z_SH +: Z_W];
        end
    end

    // Stage 3: split rays into sign and magnitude
    assign mag_x_full = ray_x_reg[RAY_W-1] ? (~ray_x_reg + RAY_W'(1)) : ray_x_reg;
    assign mag_y_full = ray_y_reg[RAY_W-1] ? (~ray_y_reg + RAY_W'(1)) : ray_y_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            mag_x_reg  <= mag_x_full[MAG_W-1:0];
            mag_y_reg  <= mag_y_full[MAG_W-1:0];
            neg_x3_reg <= ray_x_reg[RAY_W-1];
            neg_y3_reg <= ray_y_reg[RAY_W-1];
            z3_reg     <= z2_reg;
        end
    end

    // Stage 4: multiply magnitude slices by depth
    assign plo_x_next = PLO_W'(mag_x_reg[LO_W-1:0]) * PLO_W'(z3_reg);
    assign plo_y_next = PLO_W'(mag_y_reg[LO_W-1:0]) * PLO_W'(z3_reg);
    assign phi_x_next = PHI_W'(mag_x_reg[MAG_W-1:LO_W]) * PHI_W'(z3_reg);
    assign phi_y_next = PHI_W'(mag_y_reg[MAG_W-1:LO_W]) * PHI_W'(z3_reg);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            plo_x_reg  <= plo_x_next;
            plo_y_reg  <= plo_y_next;
            phi_x_reg  <= phi_x_next;
            phi_y_reg  <= phi_y_next;
            neg_x4_reg <= neg_x3_reg;
            neg_y4_reg <= neg_y3_reg;
            z4_reg     <= z3_reg;
        end
    end

    // Stage 5: recombine and drop fraction bits; round magnitude up for negatives
    assign q_x_next = (Q_W'(phi_x_reg) << HI_SH) + Q_W'(plo_x_reg[PLO_W-1:FRAC_W])
                    + Q_W'(neg_x4_reg && (plo_x_reg[FRAC_W-1:0] != '0));
    assign q_y_next = (Q_W'(phi_y_reg) << HI_SH) + Q_W'(plo_y_reg[PLO_W-1:FRAC_W])
                    + Q_W'(neg_y4_reg && (plo_y_reg[FRAC_W-1:0] != '0));

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            q_x_reg    <= q_x_next;
            q_y_reg    <= q_y_next;
            neg_x5_reg <= neg_x4_reg;
            neg_y5_reg <= neg_y4_reg;
            z5_reg     <= z4_reg;
        end
    end

    // Stage 6: saturate and hold the point for the output transaction
    assign pt_x_next = saturate(q_x_reg, neg_x5_reg);
    assign pt_y_next = saturate(q_y_reg, neg_y5_reg);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            pt_x_reg <= pt_x_next;
            pt_y_reg <= pt_y_next;
            pt_z_reg <= z5_reg;
        end
    end

    assign point.valid   = vld_reg[PIPE_STAGES-1];
    assign point.point_x = pt_x_reg;
    assign point.point_y = pt_y_reg;
    assign point.point_z = pt_z_reg;

endmodule

`default_nettype wire

@@ src/dpd_checker.sv @@
// Port-level checks for the depth pixel deprojection block, bound to the top level
`default_nettype none

module dpd_checker (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    input  wire                           in_ready,
    input  wire                           out_valid,
    input  wire                           out_ready,
    input  wire [dpd_pkg::X_W-1:0]        out_x,
    input  wire [dpd_pkg::X_W-1:0]        out_y,
    input  wire [dpd_pkg::Z_W-1:0]        out_z
);

    import dpd_pkg::*;

    localparam int OCC_W = $clog2(PIPE_STAGES + 1) + 1;

    logic [OCC_W-1:0] occ_reg, occ_next;

    // Track transactions in flight
    assign occ_next = occ_reg + OCC_W'(in_valid && in_ready) - OCC_W'(out_valid && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // A stalled point holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
                                    && $stable(out_z))
        else $error("point changed while stalled");

    // Zero depth gives the origin
    a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_z == '0) |-> (out_x == '0) && (out_y == '0))
        else $error("nonzero X or Y at zero depth");

    // Input back-pressure only comes from a stalled output
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

    // No point without a pixel in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != '0)
        else $error("point with nothing in flight");

    // Never more transactions in flight than stages
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(PIPE_STAGES))
        else $error("too many transactions in flight");

endmodule

bind depth_pixel_deprojection dpd_checker u_dpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (point.valid),
    .out_ready (point.ready),
    .out_x     (point.point_x),
    .out_y     (point.point_y),
    .out_z     (point.point_z)
);

`default_nettype wire
